// ===== hw/rtl/rrts_pkg.sv =====
`default_nettype none

package rrts_pkg;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNING  = 2'd1,
    SLOT_RUNNABLE = 2'd2,
    SLOT_ZOMBIE   = 2'd3
  } slot_t;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_YIELD  = 2'd1,
    REQ_EXIT   = 2'd2,
    REQ_JOIN   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    RC_DONE   = 3'd0,
    RC_NOSLOT = 3'd1,
    RC_WAIT   = 3'd2,
    RC_FREE   = 3'd3,
    RC_HALTED = 3'd4
  } rc_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EVAL = 2'd1,
    FSM_SCAN = 2'd2
  } fsm_t;

  typedef struct packed {
    logic latch;
    logic idle;
    logic mark_cur_runnable;
    logic mark_cur_zombie;
    logic harvest;
    logic scan_init;
    logic scan_from_zero;
    logic scan_step;
    logic claim;
    logic run_cand;
    logic set_halt;
    logic emit;
    rc_t  rc;
  } cmd_t;

  typedef struct packed {
    logic  halted;
    req_t  req;
    logic  tgt_in_range;
    slot_t tgt_state;
    logic  cand_free;
    logic  cand_runnable;
    logic  last;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrts_ctrl.sv =====
`default_nettype none

module rrts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rrts_pkg::stat_t stat,
  output rrts_pkg::cmd_t  cmd
);

  import rrts_pkg::*;

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rc     = RC_DONE;
    cmd.idle   = (state == FSM_IDLE);
    busy       = (state != FSM_IDLE);
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        if (stat.halted) begin
          cmd.emit   = 1'b1;
          cmd.rc     = RC_HALTED;
          state_next = FSM_IDLE;
        end else begin
          unique case (stat.req)
            REQ_CREATE: begin
              cmd.scan_init      = 1'b1;
              cmd.scan_from_zero = 1'b1;
              state_next         = FSM_SCAN;
            end
            REQ_YIELD: begin
              cmd.mark_cur_runnable = 1'b1;
              cmd.scan_init         = 1'b1;
              state_next            = FSM_SCAN;
            end
            REQ_EXIT: begin
              cmd.mark_cur_zombie = 1'b1;
              cmd.scan_init       = 1'b1;
              state_next          = FSM_SCAN;
            end
            REQ_JOIN: begin
              if (!stat.tgt_in_range || stat.tgt_state == SLOT_FREE) begin
                cmd.emit   = 1'b1;
                cmd.rc     = RC_FREE;
                state_next = FSM_IDLE;
              end else if (stat.tgt_state == SLOT_ZOMBIE) begin
                cmd.harvest = 1'b1;
                cmd.emit    = 1'b1;
                cmd.rc      = RC_DONE;
                state_next  = FSM_IDLE;
              end else begin
                cmd.mark_cur_runnable = 1'b1;
                cmd.scan_init         = 1'b1;
                state_next            = FSM_SCAN;
              end
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (stat.req == REQ_CREATE) begin
          if (stat.cand_free) begin
            cmd.claim  = 1'b1;
            cmd.emit   = 1'b1;
            cmd.rc     = RC_DONE;
            state_next = FSM_IDLE;
          end else if (stat.last) begin
            cmd.emit   = 1'b1;
            cmd.rc     = RC_NOSLOT;
            state_next = FSM_IDLE;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end else begin
          cmd.rc = (stat.req == REQ_JOIN) ? RC_WAIT : RC_DONE;
          if (stat.cand_runnable) begin
            cmd.run_cand = 1'b1;
            cmd.emit     = 1'b1;
            state_next   = FSM_IDLE;
          end else if (stat.last) begin
            cmd.set_halt = 1'b1;
            cmd.emit     = 1'b1;
            if (stat.req == REQ_EXIT) begin
              cmd.rc = RC_HALTED;
            end
            state_next = FSM_IDLE;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_scan_after_eval: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN) |-> (stat.req != REQ_JOIN || stat.tgt_in_range))
    else $error("join scan started on an out-of-range target");

  a_halted_short: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_EVAL && stat.halted) |=> (state == FSM_IDLE))
    else $error("halted request did not finish at once");

endmodule

`default_nettype wire

// ===== hw/rtl/rrts_dp.sv =====
`default_nettype none

module rrts_dp #(
  parameter int THREAD_SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rrts_pkg::cmd_t       cmd,
  output rrts_pkg::stat_t      stat,
  input  logic [1:0]           req_type,
  input  logic signed [31:0]   exit_code,
  input  logic [1:0]           target_slot,
  output logic                 done,
  output logic [2:0]           result_code,
  output logic [1:0]           created_slot,
  output logic [1:0]           running_slot,
  output logic [1:0]           previous_slot,
  output logic                 switch_needed,
  output logic                 harvested_valid,
  output logic signed [31:0]   harvested_code
);

  import rrts_pkg::*;

  localparam int SW = (THREAD_SLOTS > 2) ? $clog2(THREAD_SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(THREAD_SLOTS - 1);

  slot_t       slot_state [THREAD_SLOTS];
  logic [31:0] exit_value [THREAD_SLOTS];
  logic [31:0] rd_data;
  logic [SW-1:0] cur;
  logic [SW-1:0] cand;
  logic [SW-1:0] cnt;
  logic [SW-1:0] created;
  logic [SW-1:0] prev;
  logic          halted_flag;
  req_t          req;
  logic [31:0]   code;
  logic [1:0]    tgt;

  logic [SW+1:0] tgt_ext;
  logic [SW+1:0] tin_ext;
  logic [SW-1:0] tgt_idx;
  logic [SW-1:0] rd_addr;
  logic [SW+1:0] cur_ext;
  logic [SW+1:0] created_ext;
  logic [SW+1:0] prev_ext;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] x);
    slot_inc = (x == LAST) ? '0 : x + 1'b1;
  endfunction

  assign tgt_ext = {SW'(0), tgt};
  assign tin_ext = {SW'(0), target_slot};
  assign tgt_idx = tgt_ext[SW-1:0];
  assign rd_addr = tin_ext[SW-1:0];

  always_comb begin
    stat.halted        = halted_flag;
    stat.req           = req;
    stat.tgt_in_range  = (tgt_ext < (SW+2)'(THREAD_SLOTS));
    stat.tgt_state     = slot_state[tgt_idx];
    stat.cand_free     = (slot_state[cand] == SLOT_FREE);
    stat.cand_runnable = (slot_state[cand] == SLOT_RUNNABLE);
    stat.last          = (cnt == LAST);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req  <= req_t'(req_type);
      code <= exit_code;
      tgt  <= target_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rd_data <= exit_value[rd_addr];
    end
    if (cmd.mark_cur_zombie) begin
      exit_value[cur] <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        slot_state[i] <= (i == 0) ? SLOT_RUNNING : SLOT_FREE;
      end
    end else if (cmd.mark_cur_runnable) begin
      slot_state[cur] <= SLOT_RUNNABLE;
    end else if (cmd.mark_cur_zombie) begin
      slot_state[cur] <= SLOT_ZOMBIE;
    end else if (cmd.harvest) begin
      slot_state[tgt_idx] <= SLOT_FREE;
    end else if (cmd.claim) begin
      slot_state[cand] <= SLOT_RUNNABLE;
    end else if (cmd.run_cand) begin
      slot_state[cand] <= SLOT_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cand <= cmd.scan_from_zero ? '0 : slot_inc(cur);
      cnt  <= '0;
    end else if (cmd.scan_step) begin
      cand <= slot_inc(cand);
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur         <= '0;
      halted_flag <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.run_cand && cand != cur) begin
        cur <= cand;
      end
      if (cmd.set_halt) begin
        halted_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      created         <= '0;
      prev            <= '0;
      switch_needed   <= 1'b0;
      harvested_valid <= 1'b0;
      harvested_code  <= '0;
    end else begin
      if (cmd.claim) begin
        created <= cand;
      end
      if (cmd.run_cand && cand != cur) begin
        prev          <= cur;
        switch_needed <= 1'b1;
      end
      if (cmd.harvest) begin
        harvested_valid <= 1'b1;
        harvested_code  <= rd_data;
      end
    end
    if (cmd.emit) begin
      result_code <= cmd.rc;
    end
  end

  assign cur_ext       = {2'b00, cur};
  assign created_ext   = {2'b00, created};
  assign prev_ext      = {2'b00, prev};
  assign running_slot  = cur_ext[1:0];
  assign created_slot  = created_ext[1:0];
  assign previous_slot = prev_ext[1:0];

  a_running_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.idle && !halted_flag) |-> (slot_state[cur] == SLOT_RUNNING))
    else $error("running slot not marked running while idle");

  a_switch_prev: assert property (@(posedge clk) disable iff (rst)
    (done && switch_needed) |-> (prev != cur))
    else $error("switch reported onto the same slot");

  a_harvest_done: assert property (@(posedge clk) disable iff (rst)
    (done && harvested_valid) |-> (result_code == RC_DONE && !switch_needed))
    else $error("harvest reported with a bad result code or a switch");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted_flag |=> halted_flag)
    else $error("halted flag cleared");

endmodule

`default_nettype wire

// ===== hw/rtl/round_robin_thread_scheduler_top.sv =====
`default_nettype none

// Round-robin thread scheduler. A request is taken when start is high and busy
// is low; its result appears for exactly one cycle with done high, and the
// receiver cannot hold it off. Busy stays high while a request is in work, so
// a new request is never taken before the last one finishes. A halted block,
// or a join that harvests or finds a free target, finishes without a scan; a
// create scans up from slot 0 for the lowest free slot, and a yield, exit or
// waiting join scans on from the slot after the running one for the next
// runnable slot, which may be the running slot itself, and halts if it finds
// none. The slot scan examines one slot a cycle. Exit values are undefined
// until an exit writes them; once no slot is runnable the block answers every
// request as halted until reset.
module round_robin_thread_scheduler_top #(
  parameter int THREAD_SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  exit_code,
  input  logic [1:0]          target_slot,
  output logic                done,
  output logic [2:0]          result_code,
  output logic [1:0]          created_slot,
  output logic [1:0]          running_slot,
  output logic [1:0]          previous_slot,
  output logic                switch_needed,
  output logic                harvested_valid,
  output logic signed [31:0]  harvested_code
);

  import rrts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rrts_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (req_type),
    .exit_code       (exit_code),
    .target_slot     (target_slot),
    .done            (done),
    .result_code     (result_code),
    .created_slot    (created_slot),
    .running_slot    (running_slot),
    .previous_slot   (previous_slot),
    .switch_needed   (switch_needed),
    .harvested_valid (harvested_valid),
    .harvested_code  (harvested_code)
  );

endmodule

`default_nettype wire

// ===== tb/round_robin_thread_scheduler_top_test.sv =====
`timescale 1ns / 100ps

module round_robin_thread_scheduler_top_test;
  import rrts_pkg::*;

  localparam int NUM_SLOTS      = 4;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    rc_t         rc;
    logic [1:0]  created;
    logic [1:0]  running;
    logic [1:0]  prev;
    logic        sw;
    logic        hvalid;
    logic [31:0] hcode;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         req_type = 2'd0;
  logic signed [31:0] exit_code = 32'sd0;
  logic [1:0]         target_slot = 2'd0;
  logic               busy;
  logic               done;
  logic [2:0]         result_code;
  logic [1:0]         created_slot;
  logic [1:0]         running_slot;
  logic [1:0]         previous_slot;
  logic               switch_needed;
  logic               harvested_valid;
  logic signed [31:0] harvested_code;

  slot_t         slot_tab [NUM_SLOTS];
  logic [31:0]   exit_tab [NUM_SLOTS];
  int            cur_slot;
  bit            halted;
  sched_result_t pending_results[$];
  sched_result_t due_result;
  int            error_count = 0;
  int            stall_cycles = 0;
  bit            idle_on = 1'b1;

  round_robin_thread_scheduler_top #(.THREAD_SLOTS(NUM_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .exit_code(exit_code),
    .target_slot(target_slot),
    .done(done),
    .result_code(result_code),
    .created_slot(created_slot),
    .running_slot(running_slot),
    .previous_slot(previous_slot),
    .switch_needed(switch_needed),
    .harvested_valid(harvested_valid),
    .harvested_code(harvested_code)
  );

  always #6 clk = ~clk;

  function automatic bit reschedule(inout sched_result_t res);
    int cand;
    int i;
    cand = cur_slot;
    for (i = 0; i < NUM_SLOTS; i++) begin
      cand = (cand + 1) % NUM_SLOTS;
      if (slot_tab[cand] == SLOT_RUNNABLE) begin
        slot_tab[cand] = SLOT_RUNNING;
        if (cand != cur_slot) begin
          res.prev = cur_slot[1:0];
          res.sw   = 1'b1;
          cur_slot = cand;
        end
        return 1'b1;
      end
    end
    halted = 1'b1;
    return 1'b0;
  endfunction

  function automatic sched_result_t apply_request(req_t kind, logic [31:0] code,
                                                  logic [1:0] tgt);
    sched_result_t res;
    int i;
    res = '0;
    res.rc = RC_DONE;
    if (halted) begin
      res.rc = RC_HALTED;
    end else begin
      case (kind)
        REQ_CREATE: begin
          res.rc = RC_NOSLOT;
          for (i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_tab[i] == SLOT_FREE) begin
              res.rc = RC_DONE;
              res.created = i[1:0];
            end
          end
          if (res.rc == RC_DONE) slot_tab[res.created] = SLOT_RUNNABLE;
        end
        REQ_YIELD: begin
          slot_tab[cur_slot] = SLOT_RUNNABLE;
          void'(reschedule(res));
        end
        REQ_EXIT: begin
          exit_tab[cur_slot] = code;
          slot_tab[cur_slot] = SLOT_ZOMBIE;
          if (!reschedule(res)) res.rc = RC_HALTED;
        end
        default: begin
          if (tgt >= NUM_SLOTS || slot_tab[tgt] == SLOT_FREE) begin
            res.rc = RC_FREE;
          end else if (slot_tab[tgt] == SLOT_ZOMBIE) begin
            res.hvalid = 1'b1;
            res.hcode = exit_tab[tgt];
            slot_tab[tgt] = SLOT_FREE;
          end else begin
            res.rc = RC_WAIT;
            slot_tab[cur_slot] = SLOT_RUNNABLE;
            void'(reschedule(res));
          end
        end
      endcase
    end
    res.running = cur_slot[1:0];
    return res;
  endfunction

  task automatic send_request(req_t kind, logic [31:0] code, logic [1:0] tgt);
    if (idle_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= kind;
    exit_code   <= code;
    target_slot <= tgt;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(kind, code, tgt));
  endtask

  task automatic report_mismatch(string field, longint due, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, due, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual code %0d",
                 $time, result_code);
        error_count++;
      end else begin
        due_result = pending_results.pop_front();
        if (result_code !== due_result.rc)
          report_mismatch("result_code", due_result.rc, result_code);
        if (created_slot !== due_result.created)
          report_mismatch("created_slot", due_result.created, created_slot);
        if (running_slot !== due_result.running)
          report_mismatch("running_slot", due_result.running, running_slot);
        if (previous_slot !== due_result.prev)
          report_mismatch("previous_slot", due_result.prev, previous_slot);
        if (switch_needed !== due_result.sw)
          report_mismatch("switch_needed", due_result.sw, switch_needed);
        if (harvested_valid !== due_result.hvalid)
          report_mismatch("harvested_valid", due_result.hvalid, harvested_valid);
        if (harvested_code !== due_result.hcode)
          report_mismatch("harvested_code", $signed(due_result.hcode), harvested_code);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("round_robin_thread_scheduler_top test failed");
      $finish;
    end
  end

  task automatic test_directed_sequence;
    send_request(REQ_JOIN,   $urandom, 2'd1);
    send_request(REQ_CREATE, $urandom, 2'd0);
    send_request(REQ_CREATE, $urandom, 2'd3);
    send_request(REQ_CREATE, $urandom, 2'd2);
    send_request(REQ_CREATE, $urandom, 2'd1);
    send_request(REQ_YIELD,  $urandom, 2'd0);
    send_request(REQ_JOIN,   $urandom, 2'd1);
    send_request(REQ_EXIT,   32'h7FFF_FFFF, 2'd3);
    send_request(REQ_JOIN,   $urandom, 2'd2);
    send_request(REQ_JOIN,   $urandom, 2'd0);
    send_request(REQ_EXIT,   32'h8000_0000, 2'd0);
    send_request(REQ_JOIN,   $urandom, 2'd0);
    send_request(REQ_CREATE, $urandom, 2'd3);
    send_request(REQ_EXIT,   32'hFFFF_FFFF, 2'd1);
    send_request(REQ_EXIT,   32'h0000_0000, 2'd2);
    send_request(REQ_YIELD,  $urandom, 2'd3);
    send_request(REQ_JOIN,   $urandom, 2'd3);
    send_request(REQ_JOIN,   $urandom, 2'd1);
    send_request(REQ_JOIN,   $urandom, 2'd2);
    send_request(REQ_JOIN,   $urandom, 2'd0);
    send_request(REQ_CREATE, $urandom, 2'd0);
    send_request(REQ_EXIT,   32'hAAAA_AAAA, 2'd0);
    send_request(REQ_JOIN,   $urandom, 2'd0);
  endtask

  task automatic test_random_mix;
    int n;
    int i;
    int pick;
    bit other_runnable;
    req_t kind;
    logic [1:0] tgt;
    int zombies[$];
    for (n = 0; n < 600; n++) begin
      idle_on = !(n >= 250 && n < 400);
      pick = $urandom_range(99);
      tgt = 2'($urandom_range(3));
      if (pick < 25) kind = REQ_CREATE;
      else if (pick < 50) kind = REQ_YIELD;
      else if (pick < 70) kind = REQ_EXIT;
      else kind = REQ_JOIN;
      if (kind == REQ_EXIT) begin
        other_runnable = 1'b0;
        for (i = 0; i < NUM_SLOTS; i++)
          if (i != cur_slot && slot_tab[i] == SLOT_RUNNABLE) other_runnable = 1'b1;
        if (!other_runnable) kind = $urandom_range(1) ? REQ_CREATE : REQ_JOIN;
      end
      if (kind == REQ_JOIN) begin
        zombies.delete();
        for (i = 0; i < NUM_SLOTS; i++)
          if (slot_tab[i] == SLOT_ZOMBIE) zombies.push_back(i);
        if (zombies.size() > 0 && $urandom_range(99) < 60)
          tgt = 2'(zombies[$urandom_range(zombies.size() - 1)]);
      end
      send_request(kind, $urandom, tgt);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_halt;
    int i;
    while (!halted) send_request(REQ_EXIT, $urandom, 2'($urandom_range(3)));
    for (i = 0; i < 4; i++) send_request(req_t'(i), $urandom, 2'($urandom_range(3)));
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_tab[i] = SLOT_FREE;
      exit_tab[i] = '0;
    end
    slot_tab[0] = SLOT_RUNNING;
    cur_slot = 0;
    halted = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_sequence();
    test_random_mix();
    test_halt();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("round_robin_thread_scheduler_top test passed");
    end else begin
      $display("round_robin_thread_scheduler_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/rrts_dp.sv
hw/rtl/round_robin_thread_scheduler_top.sv
tb/round_robin_thread_scheduler_top_test.sv
